// ----- sv/mdg_pkg.sv -----
package mdg_pkg;

  // Fixed port widths
  localparam int unsigned DIVISOR_W = 32;
  localparam int unsigned SHIFT_W   = 5;

endpackage

// ----- sv/mdg_div_step.sv -----
// One restoring division step: one quotient bit per stage, with its own
// valid bit and a stall that ripples back only through full stages.
module mdg_div_step
  import mdg_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [WORD_BITS-1:0] up_rem,
  input  logic [WORD_BITS-1:0] up_quo,
  input  logic [WORD_BITS-1:0] up_dvs,
  input  logic [SHIFT_W-1:0]   up_shift,
  input  logic                 up_bad,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic [WORD_BITS-1:0] dn_rem,
  output logic [WORD_BITS-1:0] dn_quo,
  output logic [WORD_BITS-1:0] dn_dvs,
  output logic [SHIFT_W-1:0]   dn_shift,
  output logic                 dn_bad
);

  logic                 vld;
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] dvs;
  logic [SHIFT_W-1:0]   shift;
  logic                 bad;

  logic                 adv;
  logic [WORD_BITS:0]   rem_dbl;
  logic [WORD_BITS:0]   rem_sub;
  logic                 take;
  logic [WORD_BITS-1:0] rem_next;
  logic [WORD_BITS-1:0] quo_next;

  // stage moves when empty or when the next stage takes its beat
  assign adv      = !vld || dn_ready;
  assign up_ready = adv;

  // shift in a zero numerator bit, subtract divisor if it fits
  always_comb begin
    rem_dbl  = {up_rem, 1'b0};
    rem_sub  = rem_dbl - {1'b0, up_dvs};
    take     = (rem_dbl >= {1'b0, up_dvs});
    rem_next = take ? rem_sub[WORD_BITS-1:0] : rem_dbl[WORD_BITS-1:0];
    quo_next = {up_quo[WORD_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      rem   <= rem_next;
      quo   <= quo_next;
      dvs   <= up_dvs;
      shift <= up_shift;
      bad   <= up_bad;
    end
  end

  assign dn_valid = vld;
  assign dn_rem   = rem;
  assign dn_quo   = quo;
  assign dn_dvs   = dvs;
  assign dn_shift = shift;
  assign dn_bad   = bad;

endmodule

// ----- sv/magic_divisor_generator.sv -----
// Magic-number generator for unsigned division by an invariant divisor.
// For each divisor d it returns shift_amount = ceil(log2(d)) and
// magic_value = floor(2^WORD_BITS * (2^shift - d) / d) + 1, so that later
// logic can divide by d with a multiply and a shift. A divisor of zero or
// above 2^(WORD_BITS-1)-1 raises invalid and returns zeros. The block is a
// pipeline of WORD_BITS+3 register stages: input capture, shift search,
// remainder set-up, then one restoring division stage per quotient bit.
// It accepts one divisor every cycle while the result side does not stall,
// and each result leaves the last division stage; a stall on the result
// side holds only the stages that are full.
module magic_divisor_generator
  import mdg_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 divisor_valid,
  output logic                 divisor_ready,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [31:0]          magic_value,
  output logic [SHIFT_W-1:0]   shift_amount,
  output logic                 invalid
);

  localparam logic [DIVISOR_W-1:0] LIMIT =
    DIVISOR_W'((64'd1 << (WORD_BITS - 1)) - 64'd1);

  // ---------------- stage 0: capture, range check, d-1
  logic                 v0;
  logic [WORD_BITS-1:0] d0;
  logic [WORD_BITS-1:0] dm0;
  logic                 bad0;
  logic                 adv0;
  logic                 adv1;
  logic                 adv2;

  assign adv0          = !v0 || adv1;
  assign divisor_ready = adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv0) begin
      v0 <= divisor_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && divisor_valid) begin
      d0   <= divisor[WORD_BITS-1:0];
      dm0  <= divisor[WORD_BITS-1:0] - WORD_BITS'(1);
      bad0 <= (divisor == '0) || (divisor > LIMIT);
    end
  end

  // ---------------- stage 1: shift = bit length of d-1
  logic                 v1;
  logic [WORD_BITS-1:0] d1;
  logic [SHIFT_W-1:0]   s1;
  logic                 bad1;
  logic [SHIFT_W-1:0]   s_next;

  assign adv1 = !v1 || adv2;

  always_comb begin
    s_next = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (dm0[i]) begin
        s_next = SHIFT_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && v0) begin
      d1   <= d0;
      s1   <= s_next;
      bad1 <= bad0;
    end
  end

  // ---------------- stage 2: starting remainder 2^shift - d
  logic                 v2;
  logic [WORD_BITS-1:0] d2;
  logic [WORD_BITS-1:0] r2;
  logic [SHIFT_W-1:0]   s2;
  logic                 bad2;

  // division chain, index 0 fed by stage 2
  logic                 c_valid [0:WORD_BITS];
  logic                 c_ready [0:WORD_BITS];
  logic [WORD_BITS-1:0] c_rem   [0:WORD_BITS];
  logic [WORD_BITS-1:0] c_quo   [0:WORD_BITS];
  logic [WORD_BITS-1:0] c_dvs   [0:WORD_BITS];
  logic [SHIFT_W-1:0]   c_shift [0:WORD_BITS];
  logic                 c_bad   [0:WORD_BITS];

  assign adv2 = !v2 || c_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      d2   <= d1;
      r2   <= (WORD_BITS'(1) << s1) - d1;
      s2   <= s1;
      bad2 <= bad1;
    end
  end

  assign c_valid[0] = v2;
  assign c_rem[0]   = r2;
  assign c_quo[0]   = '0;
  assign c_dvs[0]   = d2;
  assign c_shift[0] = s2;
  assign c_bad[0]   = bad2;

  // ---------------- one stage per quotient bit
  for (genvar k = 0; k < WORD_BITS; k++) begin : g_step
    mdg_div_step #(
      .WORD_BITS (WORD_BITS)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .up_valid (c_valid[k]),
      .up_ready (c_ready[k]),
      .up_rem   (c_rem[k]),
      .up_quo   (c_quo[k]),
      .up_dvs   (c_dvs[k]),
      .up_shift (c_shift[k]),
      .up_bad   (c_bad[k]),
      .dn_valid (c_valid[k+1]),
      .dn_ready (c_ready[k+1]),
      .dn_rem   (c_rem[k+1]),
      .dn_quo   (c_quo[k+1]),
      .dn_dvs   (c_dvs[k+1]),
      .dn_shift (c_shift[k+1]),
      .dn_bad   (c_bad[k+1])
    );
  end

  // ---------------- result beat from the last stage
  logic [WORD_BITS-1:0] magic_w;

  // quotient plus one; an out-of-range divisor gives zeros
  assign magic_w      = c_quo[WORD_BITS] + WORD_BITS'(1);
  assign c_ready[WORD_BITS] = result_ready;
  assign result_valid = c_valid[WORD_BITS];
  assign magic_value  = c_bad[WORD_BITS] ? 32'd0 : 32'(magic_w);
  assign shift_amount = c_bad[WORD_BITS] ? '0 : c_shift[WORD_BITS];
  assign invalid      = c_bad[WORD_BITS];

endmodule
